FILE: design/wcba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcba_pkg: shared types and a helper for the window clamp block
// Item layouts, queue depths and the one-dimensional overlap length.
// ----------------------------------------------------------------------------
package wcba_pkg;

    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 2;

    localparam logic CMD_WINDOW = 1'b0;
    localparam logic CMD_AREA   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic [14:0]        out_width;
        logic [14:0]        out_height;
        logic               had_area;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_rect;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic        cmd;
        logic        last;
        t_rect       rect;
        t_rect       win;
        logic [14:0] span_w;
        logic [14:0] span_h;
    } t_work;

    // Everything needed to build one result.
    typedef struct packed {
        t_rect win;
        t_rect best;
        logic  seen;
    } t_fin;

    // Length of the overlap of [a0, a0+aw) and [b0, b0+bw), floored at zero.
    // A positive overlap is never longer than either width, so 15 bits hold it.
    function automatic logic [14:0] span_len(input logic signed [15:0] a0,
                                             input logic [14:0]        aw,
                                             input logic signed [15:0] b0,
                                             input logic [14:0]        bw);
        logic signed [17:0] a_lo;
        logic signed [17:0] b_lo;
        logic signed [17:0] a_hi;
        logic signed [17:0] b_hi;
        logic signed [17:0] lo;
        logic signed [17:0] hi;
        logic signed [17:0] d;
        a_lo = {{2{a0[15]}}, a0};
        b_lo = {{2{b0[15]}}, b0};
        a_hi = a_lo + $signed({3'b000, aw});
        b_hi = b_lo + $signed({3'b000, bw});
        lo   = (a_lo > b_lo) ? a_lo : b_lo;
        hi   = (a_hi < b_hi) ? a_hi : b_hi;
        d    = hi - lo;
        return (d > 18'sd0) ? d[14:0] : 15'd0;
    endfunction

endpackage

FILE: design/window_clamp_to_best_area.sv
`timescale 1ns / 1ps
// Path: a last item passes the middle queue, the back stages and the
// result queue. Throughput: one item per cycle while the middle queue has
// room; the back stalls only on a full result queue while intake goes on.
// Reset: synchronous, active low; the held window and best area clear to zero,
// and both queues come up empty.
// ----------------------------------------------------------------------------
// window_clamp_to_best_area: clamp a window into its best-overlapping area
// Front end classifies items, a middle queue decouples it from the back end,
// which selects the best area and clamps the window on the last item.
// ----------------------------------------------------------------------------
module window_clamp_to_best_area #(
    parameter int unsigned MID_DEPTH = wcba_pkg::MID_DEPTH,
    parameter int unsigned OUT_DEPTH = wcba_pkg::OUT_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  wcba_pkg::t_in_item   i_item,
    output logic                 empty,
    input  logic                 pop,
    output wcba_pkg::t_out_item  o_result
);

    logic                q_wr;
    wcba_pkg::t_work     q_wr_data;
    logic                q_rd;
    wcba_pkg::t_work     q_rd_data;
    logic                q_empty;
    logic                out_wr;
    wcba_pkg::t_out_item out_wr_data;
    logic                out_full;

    wcba_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (full),
        .o_q_wr   (q_wr),
        .o_q_data (q_wr_data)
    );

    wcba_fifo #(
        .DEPTH ($bits(wcba_pkg::t_work) > 0 ? MID_DEPTH : MID_DEPTH),
        .WIDTH ($bits(wcba_pkg::t_work))
    ) u_mid_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .o_full    (full),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty)
    );

    wcba_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_rd_data),
        .o_q_rd     (q_rd),
        .i_out_full (out_full),
        .o_out_wr   (out_wr),
        .o_out_data (out_wr_data)
    );

    wcba_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(wcba_pkg::t_out_item))
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (out_wr),
        .i_wr_data (out_wr_data),
        .o_full    (out_full),
        .i_rd      (pop),
        .o_rd_data (o_result),
        .o_empty   (empty)
    );

endmodule

FILE: design/wcba_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcba_fifo: small register queue
// First-in first-out buffer with full and empty flags; push when full and
// pop when empty are ignored.
// ----------------------------------------------------------------------------
module wcba_fifo #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             wr_go;
    logic             rd_go;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_go     = i_wr && !o_full;
    assign rd_go     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_go && !rd_go) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on a lone write");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_go == rd_go) |=> (r_count == $past(r_count)))
        else $error("queue count moved without a lone write or read");
`endif

endmodule

FILE: design/wcba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcba_front: item intake and classification
// Holds the current window, measures each area's overlap spans against it
// and hands the classified item to the middle queue.
// ----------------------------------------------------------------------------
module wcba_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wcba_pkg::t_in_item  i_item,
    input  logic                i_q_full,
    output logic                o_q_wr,
    output wcba_pkg::t_work     o_q_data
);

    wcba_pkg::t_rect r_win;
    wcba_pkg::t_rect n_win;
    wcba_pkg::t_rect in_rect;

    assign in_rect.x = i_item.rect_x;
    assign in_rect.y = i_item.rect_y;
    assign in_rect.w = i_item.rect_width;
    assign in_rect.h = i_item.rect_height;

    assign o_q_wr = i_push && !i_q_full;

    always_comb begin
        n_win = r_win;
        if (o_q_wr && (i_item.cmd == wcba_pkg::CMD_WINDOW)) begin
            n_win = in_rect;
        end
    end

    always_comb begin
        o_q_data.cmd    = i_item.cmd;
        o_q_data.last   = i_item.last;
        o_q_data.rect   = in_rect;
        // A window item carries itself as the window for the back end.
        o_q_data.win    = n_win;
        o_q_data.span_w = wcba_pkg::span_len(r_win.x, r_win.w, in_rect.x, in_rect.w);
        o_q_data.span_h = wcba_pkg::span_len(r_win.y, r_win.h, in_rect.y, in_rect.h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

endmodule

FILE: design/wcba_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcba_back: overlap selection and clamping
// Multiplies the spans, keeps the best area of the request and, on the last
// item, clamps the window into that area over two further stages.
// ----------------------------------------------------------------------------
module wcba_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  wcba_pkg::t_work      i_q_data,
    output logic                 o_q_rd,
    input  logic                 i_out_full,
    output logic                 o_out_wr,
    output wcba_pkg::t_out_item  o_out_data
);

    typedef struct packed {
        wcba_pkg::t_rect    win;
        wcba_pkg::t_rect    best;
        logic               seen;
        logic [14:0]        ow;
        logic [14:0]        oh;
        logic signed [16:0] endx;
        logic signed [16:0] endy;
    } t_s3;

    logic               adv;
    logic               r_v1;
    wcba_pkg::t_work    r_s1;
    logic [29:0]        r_prod;
    logic               r_v2;
    wcba_pkg::t_fin     r_s2;
    logic               r_v3;
    t_s3                r_s3;

    wcba_pkg::t_rect    r_best;
    logic [29:0]        r_best_ov;
    logic               r_seen;
    wcba_pkg::t_rect    n_best;
    logic [29:0]        n_best_ov;
    logic               n_seen;
    wcba_pkg::t_fin     n_s2;
    t_s3                n_s3;

    logic signed [17:0] hi_x;
    logic signed [17:0] hi_y;

    // The whole back pipeline moves together; it waits only on the result queue.
    assign adv    = !i_out_full;
    assign o_q_rd = !i_q_empty && adv;

    // Best-area selection.
    always_comb begin
        logic take;
        take      = 1'b0;
        n_best    = r_best;
        n_best_ov = r_best_ov;
        n_seen    = r_seen;
        if (r_v1 && adv) begin
            if (r_s1.cmd == wcba_pkg::CMD_WINDOW) begin
                n_seen    = 1'b0;
                n_best_ov = '0;
            end else begin
                take = !r_seen || (r_prod > r_best_ov);
                if (take) begin
                    n_best    = r_s1.rect;
                    n_best_ov = r_prod;
                end
                n_seen = 1'b1;
            end
        end
        n_s2.win  = r_s1.win;
        n_s2.best = n_best;
        n_s2.seen = n_seen;
        if (r_v1 && adv && r_s1.last) begin
            n_seen    = 1'b0;
            n_best_ov = '0;
        end
    end

    // Size clamp and far edges of the kept area.
    always_comb begin
        n_s3.win  = r_s2.win;
        n_s3.best = r_s2.best;
        n_s3.seen = r_s2.seen;
        n_s3.ow   = r_s2.win.w;
        n_s3.oh   = r_s2.win.h;
        if (r_s2.seen) begin
            if (r_s2.win.w == 15'd0) begin
                n_s3.ow = 15'd1;
            end else if (r_s2.win.w > r_s2.best.w) begin
                n_s3.ow = r_s2.best.w;
            end
            if (r_s2.win.h == 15'd0) begin
                n_s3.oh = 15'd1;
            end else if (r_s2.win.h > r_s2.best.h) begin
                n_s3.oh = r_s2.best.h;
            end
        end
        n_s3.endx = {r_s2.best.x[15], r_s2.best.x} + $signed({2'b00, r_s2.best.w});
        n_s3.endy = {r_s2.best.y[15], r_s2.best.y} + $signed({2'b00, r_s2.best.h});
    end

    function automatic logic signed [15:0] clamp_pos(input logic signed [15:0] v,
                                                     input logic signed [15:0] lo,
                                                     input logic signed [17:0] hi);
        logic signed [17:0] ve;
        logic signed [17:0] le;
        logic signed [17:0] r;
        ve = {{2{v[15]}}, v};
        le = {{2{lo[15]}}, lo};
        if (ve < le) begin
            r = le;
        end else if (ve > hi) begin
            r = hi;
        end else begin
            r = ve;
        end
        // An empty area can put the far bound one below the near edge.
        if (r < -18'sd32768) begin
            r = -18'sd32768;
        end
        return r[15:0];
    endfunction

    assign hi_x = {r_s3.endx[16], r_s3.endx} - $signed({3'b000, r_s3.ow});
    assign hi_y = {r_s3.endy[16], r_s3.endy} - $signed({3'b000, r_s3.oh});

    always_comb begin
        o_out_wr            = r_v3 && adv;
        o_out_data.out_width  = r_s3.ow;
        o_out_data.out_height = r_s3.oh;
        o_out_data.had_area   = r_s3.seen;
        if (r_s3.seen) begin
            o_out_data.out_x = clamp_pos(r_s3.win.x, r_s3.best.x, hi_x);
            o_out_data.out_y = clamp_pos(r_s3.win.y, r_s3.best.y, hi_y);
        end else begin
            o_out_data.out_x = r_s3.win.x;
            o_out_data.out_y = r_s3.win.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_seen    <= 1'b0;
            r_best_ov <= '0;
            r_best    <= '0;
        end else begin
            r_seen    <= n_seen;
            r_best_ov <= n_best_ov;
            r_best    <= n_best;
            if (adv) begin
                r_v1 <= o_q_rd;
                r_v2 <= r_v1 && r_s1.last;
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1   <= i_q_data;
            r_prod <= {15'd0, i_q_data.span_w} * {15'd0, i_q_data.span_h};
            r_s2   <= n_s2;
            r_s3   <= n_s3;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !adv) |=> (r_v3 && $stable(r_s3)))
        else $error("clamp stage changed while stalled");
    a_width_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_s3.seen && (r_s3.best.w != 15'd0)) |-> (r_s3.ow <= r_s3.best.w))
        else $error("clamped width exceeds the kept area");
    a_no_area_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_wr && !o_out_data.had_area) |->
            ((o_out_data.out_x == r_s3.win.x) && (o_out_data.out_width == r_s3.win.w)))
        else $error("window changed without an area");
    a_seen_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv && r_s1.last) |=> (!r_seen && (r_best_ov == '0)))
        else $error("request state not cleared after the last item");
`endif

endmodule

FILE: tb/window_clamp_to_best_area_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_clamp_to_best_area_test: self-checking bench for the window clamp
// Queue-style driver and monitor with random idling on both sides. Every
// accepted item runs through a bench-side clamp predictor, and each result
// popped from the block is compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module window_clamp_to_best_area_test;

    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_TAIL    = 100;

    typedef struct {
        wcba_pkg::t_in_item item;
        bit                 hold_for_drain;
    } t_pending;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push    = 1'b0;
    logic                pop     = 1'b0;
    logic                full;
    logic                empty;
    wcba_pkg::t_in_item  i_item  = '0;
    wcba_pkg::t_out_item o_result;

    t_pending            pending_items[$];
    wcba_pkg::t_out_item clamped_due[$];
    int        error_count = 0;
    int        accepted = 0;
    int        send_gap = 0;
    int        pop_gap = 0;
    int        send_idle_pct = 30;
    int        pop_idle_pct = 30;
    bit        calm = 1'b0;

    // Held window and the best area of the current request.
    longint    held_x, held_y, held_w, held_h;
    longint    pick_x, pick_y, pick_w, pick_h;
    longint    pick_overlap;
    bit        area_in_request;

    window_clamp_to_best_area DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint overlap_len(longint a0, longint aw, longint b0, longint bw);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + aw) < (b0 + bw)) ? (a0 + aw) : (b0 + bw);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    // Low bound tested first: if the bounds cross, v < lo gives lo, else hi.
    function automatic longint bound(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint sat_s16(longint v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic void predict_clamp(wcba_pkg::t_in_item it);
        longint              rx, ry, rw, rh, ov;
        longint              ox, oy, ow, oh;
        wcba_pkg::t_out_item res;
        rx = longint'($signed(it.rect_x));
        ry = longint'($signed(it.rect_y));
        rw = longint'(it.rect_width);
        rh = longint'(it.rect_height);
        if (it.cmd == wcba_pkg::CMD_WINDOW) begin
            held_x = rx;
            held_y = ry;
            held_w = rw;
            held_h = rh;
            area_in_request = 1'b0;
            pick_overlap = 0;
        end else begin
            ov = overlap_len(held_x, held_w, rx, rw) * overlap_len(held_y, held_h, ry, rh);
            if (!area_in_request || ov > pick_overlap) begin
                pick_x = rx;
                pick_y = ry;
                pick_w = rw;
                pick_h = rh;
                pick_overlap = ov;
            end
            area_in_request = 1'b1;
        end
        if (!it.last) return;
        ox = held_x;
        oy = held_y;
        ow = held_w;
        oh = held_h;
        if (area_in_request) begin
            ow = bound(ow, 1, pick_w);
            oh = bound(oh, 1, pick_h);
            ox = sat_s16(bound(ox, pick_x, pick_x + pick_w - ow));
            oy = sat_s16(bound(oy, pick_y, pick_y + pick_h - oh));
        end
        res.out_x      = ox[15:0];
        res.out_y      = oy[15:0];
        res.out_width  = ow[14:0];
        res.out_height = oh[14:0];
        res.had_area   = area_in_request;
        clamped_due.insert(clamped_due.size(), res);
        area_in_request = 1'b0;
        pick_overlap = 0;
    endfunction

    function automatic void check_result(wcba_pkg::t_out_item got);
        wcba_pkg::t_out_item want;
        if (clamped_due.size() == 0) begin
            $error("unexpected result: x %0d y %0d w %0d h %0d had_area %0d",
                   $signed(got.out_x), $signed(got.out_y), got.out_width,
                   got.out_height, got.had_area);
            error_count++;
            return;
        end
        want = clamped_due.pop_front();
        if (got.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", $signed(want.out_x), $signed(got.out_x));
            error_count++;
        end
        if (got.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", $signed(want.out_y), $signed(got.out_y));
            error_count++;
        end
        if (got.out_width !== want.out_width) begin
            $error("out_width: expected %0d, got %0d", want.out_width, got.out_width);
            error_count++;
        end
        if (got.out_height !== want.out_height) begin
            $error("out_height: expected %0d, got %0d", want.out_height, got.out_height);
            error_count++;
        end
        if (got.had_area !== want.had_area) begin
            $error("had_area: expected %0d, got %0d", want.had_area, got.had_area);
            error_count++;
        end
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 15;
            2: return 40;
            default: return 70;
        endcase
    endfunction

    function automatic void add_item(logic cmd, int x, int y, int w, int h, logic last,
                                     bit hold = 1'b0);
        t_pending p;
        p.item.cmd         = cmd;
        p.item.rect_x      = 16'(x);
        p.item.rect_y      = 16'(y);
        p.item.rect_width  = 15'(w);
        p.item.rect_height = 15'(h);
        p.item.last        = last;
        p.hold_for_drain   = hold;
        pending_items.insert(pending_items.size(), p);
    endfunction

    // Mostly near the origin so that windows and areas overlap often.
    function automatic int rand_pos();
        case ($urandom_range(9))
            0: return int'($signed(16'($urandom)));
            1: return $urandom_range(1) ? 32767 : -32768;
            default: return int'($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    function automatic int rand_size();
        case ($urandom_range(9))
            0: return int'($urandom_range(0, 32767));
            1: return 0;
            2: return 32767;
            default: return int'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic void add_random(logic cmd, logic last, bit hold = 1'b0);
        add_item(cmd, rand_pos(), rand_pos(), rand_size(), rand_size(), last, hold);
    endfunction

    // Driver: presents pending items and predicts each one as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_clamp(i_item);
                accepted++;
                if (accepted % 80 == 0) begin
                    send_idle_pct = pick_idle_pct();
                    pop_idle_pct  = pick_idle_pct();
                end
            end
            calm = (pending_items.size() < CALM_TAIL);
            if (!push || !full) begin
                if (send_gap > 0 && !calm) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    push <= 1'b0;
                end else if (pending_items[0].hold_for_drain && clamped_due.size() != 0) begin
                    push <= 1'b0;
                end else if (!calm && $urandom_range(99) < send_idle_pct) begin
                    send_gap = $urandom_range(1, 11) - 1;
                    push <= 1'b0;
                end else begin
                    i_item <= pending_items[0].item;
                    pending_items.pop_front();
                    push <= 1'b1;
                end
            end
        end
    end

    // Monitor: takes results with random stalls and checks each one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_result(o_result);
            end
            if (pop_gap > 0 && !calm) begin
                pop_gap--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(99) < pop_idle_pct) begin
                pop_gap = $urandom_range(1, 11) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int n_areas;
        int kind;
        held_x = 0; held_y = 0; held_w = 0; held_h = 0;
        pick_x = 0; pick_y = 0; pick_w = 0; pick_h = 0;
        pick_overlap = 0;
        area_in_request = 1'b0;

        // Areas before any window measure against the all-zero window; the
        // second one drives the position below the 16-bit range.
        add_item(wcba_pkg::CMD_AREA, 10, -5, 100, 50, 1'b1);
        add_item(wcba_pkg::CMD_AREA, -32768, -32768, 0, 0, 1'b1);
        // A window marked last comes back unchanged.
        add_item(wcba_pkg::CMD_WINDOW, -32768, 32767, 32767, 0, 1'b1);
        // An area right after a result starts a new request on the held window.
        add_item(wcba_pkg::CMD_AREA, 0, 0, 32767, 32767, 1'b1);
        // Equal overlaps: the earlier area is kept.
        add_item(wcba_pkg::CMD_WINDOW, 100, 100, 50, 40, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 90, 90, 20, 20, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 140, 130, 20, 20, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 0, 0, 0, 0, 1'b0);
        add_item(wcba_pkg::CMD_AREA, -32768, -32768, 32767, 32767, 1'b1);
        // A zero-sized area: width and height clamp to zero.
        add_item(wcba_pkg::CMD_WINDOW, 5, 5, 30, 30, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 0, 0, 0, 0, 1'b1);
        // Largest possible overlap.
        add_item(wcba_pkg::CMD_WINDOW, -32768, -32768, 32767, 32767, 1'b0);
        add_item(wcba_pkg::CMD_AREA, -32768, -32768, 32767, 32767, 1'b1);
        // Right and bottom edges well past the 16-bit range.
        add_item(wcba_pkg::CMD_WINDOW, 32767, 32767, 32767, 32767, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 32000, -100, 500, 600, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 32700, 32700, 67, 67, 1'b1);
        // A new window drops the areas seen so far.
        add_item(wcba_pkg::CMD_WINDOW, 1, 1, 10, 10, 1'b0);
        add_item(wcba_pkg::CMD_AREA, 0, 0, 5, 5, 1'b0);
        add_item(wcba_pkg::CMD_WINDOW, 20, 20, 3, 3, 1'b1);
        add_item(wcba_pkg::CMD_WINDOW, 0, 0, 32767, 32767, 1'b0, 1'b1);
        add_item(wcba_pkg::CMD_AREA, 16383, 16383, 16384, 16384, 1'b0);
        add_item(wcba_pkg::CMD_AREA, -1, -1, 1, 1, 1'b1);

        while (pending_items.size() < 22 + RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 85) begin
                n_areas = $urandom_range(0, 5);
                add_random(wcba_pkg::CMD_WINDOW, n_areas == 0, $urandom_range(99) < 2);
                for (int k = 0; k < n_areas; k++) begin
                    add_random(wcba_pkg::CMD_AREA, k == n_areas - 1);
                end
            end else if (kind < 93) begin
                n_areas = $urandom_range(1, 3);
                for (int k = 0; k < n_areas; k++) begin
                    add_random(wcba_pkg::CMD_AREA, k == n_areas - 1);
                end
            end else begin
                add_random(logic'($urandom_range(1)), logic'($urandom_range(1)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || push || clamped_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("window_clamp_to_best_area_test: clean");
        end else begin
            $display("window_clamp_to_best_area_test: errors");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("window_clamp_to_best_area_test: errors");
        $finish;
    end

endmodule
